// File: design/fitch_parsimony_set_engine_assert.svh
// ----------------------------------------------------------------------------
// Fitch parsimony set engine assertion macros
// Shorthand for clocked implications, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef FITCH_PARSIMONY_SET_ENGINE_ASSERT_SVH
`define FITCH_PARSIMONY_SET_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fps_pkg.sv
// ----------------------------------------------------------------------------
// Fitch parsimony set engine package
// Sizes, codes, beat types and shared helper functions.
// ----------------------------------------------------------------------------
package fps_pkg;

	localparam int NODES    = 64;
	localparam int CHARS    = 256;
	localparam int SET_BITS = 32;

	localparam int NODE_W   = $clog2(NODES);
	localparam int CHAR_W   = $clog2(CHARS);
	localparam int ADDR_W   = NODE_W + CHAR_W;
	localparam int SET_W    = SET_BITS;
	localparam int CNT_W    = 16;
	localparam int SCORE_W  = 32;
	localparam int WEIGHT_W = 16;
	localparam int DEPTH    = NODES * CHARS;

	typedef enum logic [2:0] {
		ACT_DOWN  = 3'd0,
		ACT_ROOT  = 3'd1,
		ACT_UP    = 3'd2,
		ACT_TIP   = 3'd3,
		ACT_LOCAL = 3'd4,
		ACT_LOAD  = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_CALC
	} state_t;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SET_W-1:0]  set_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  node;
		logic [5:0]  left;
		logic [5:0]  right;
		logic [5:0]  ancestor;
		logic [7:0]  char_index;
		logic [15:0] weight;
		logic [31:0] set_value;
		logic [31:0] limit;
		logic        limit_on;
		logic        first_of_pass;
	} item_beat_t;

	typedef struct packed {
		logic [31:0] result_set;
		logic [15:0] cost_added;
		logic [31:0] pass_cost;
		logic [31:0] total_score;
		logic [15:0] change_count;
		logic        over_limit;
	} result_beat_t;

	typedef struct packed {
		logic  rd_en;
		addr_t down_rd_addr;
		addr_t up_rd_addr;
		logic  down_wr_en;
		logic  up_wr_en;
		addr_t wr_addr;
		set_t  wr_data;
	} set_mem_req_t;

	typedef struct packed {
		set_t down_rd_data;
		set_t up_rd_data;
	} set_mem_rsp_t;

	typedef struct packed {
		logic             rd_en;
		char_t            rd_addr;
		logic             wr_en;
		char_t            wr_addr;
		logic [CNT_W-1:0] wr_data;
	} cnt_req_t;

	function automatic addr_t slot(logic [5:0] n, logic [7:0] c);
		return {n[NODE_W-1:0], c[CHAR_W-1:0]};
	endfunction

	function automatic logic [SCORE_W-1:0] sat_add(logic [SCORE_W-1:0] a,
			logic [WEIGHT_W-1:0] b);
		logic [SCORE_W:0] s;
		s = {1'b0, a} + (SCORE_W+1)'(b);
		return s[SCORE_W] ? '1 : s[SCORE_W-1:0];
	endfunction

endpackage

// File: design/fps_set_mem.sv
// ----------------------------------------------------------------------------
// Fitch parsimony set memories
// Down-pass and up-pass set stores, one read and one write port each.
// ----------------------------------------------------------------------------
module fps_set_mem (
	input  logic                 clk,
	input  fps_pkg::set_mem_req_t req,
	output fps_pkg::set_mem_rsp_t rsp
);
	import fps_pkg::*;

	set_t down_mem [DEPTH];
	set_t up_mem   [DEPTH];
	set_t down_rd_q;
	set_t up_rd_q;

	always_ff @(posedge clk) begin
		if (req.down_wr_en) begin
			down_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			down_rd_q <= down_mem[req.down_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.up_wr_en) begin
			up_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			up_rd_q <= up_mem[req.up_rd_addr];
		end
	end

	assign rsp.down_rd_data = down_rd_q;
	assign rsp.up_rd_data   = up_rd_q;

endmodule

// File: design/fps_count_mem.sv
// ----------------------------------------------------------------------------
// Fitch parsimony change counters
// Per-character change count store; entries never written read as zero.
// ----------------------------------------------------------------------------
module fps_count_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fps_pkg::cnt_req_t            req,
	output logic [fps_pkg::CNT_W-1:0]    rd_data
);
	import fps_pkg::*;

	logic [CNT_W-1:0] cnt_mem [CHARS];
	logic [CHARS-1:0] valid_q;
	logic [CNT_W-1:0] rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			cnt_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= cnt_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// File: design/fps_ctrl.sv
// ----------------------------------------------------------------------------
// Fitch parsimony sequencer and datapath
// Reads the operand sets, applies the Fitch rule, writes back and keeps
// the pass cost, total score and result register.
// ----------------------------------------------------------------------------
module fps_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  fps_pkg::item_beat_t          item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output fps_pkg::result_beat_t        result,
	output fps_pkg::set_mem_req_t        mem_req,
	input  fps_pkg::set_mem_rsp_t        mem_rsp,
	output fps_pkg::cnt_req_t            cnt_req,
	input  logic [fps_pkg::CNT_W-1:0]    cnt_rd_data
);
	import fps_pkg::*;

	state_t             state_q;
	state_t             state_d;
	item_beat_t         item_q;
	set_t               d0_q;
	set_t               d1_q;
	set_t               u0_q;
	set_t               u1_q;
	logic [SCORE_W-1:0] pass_q;
	logic [SCORE_W-1:0] total_q;
	result_beat_t       result_q;
	logic               result_valid_q;

	logic               accept;
	logic               done;
	set_t               d2;
	set_t               res;
	set_t               tmp;
	logic [WEIGHT_W-1:0] cost;
	logic [SCORE_W-1:0] base;
	logic [SCORE_W-1:0] pass_d;
	logic [SCORE_W-1:0] total_d;
	logic [CNT_W-1:0]   cnt_d;
	logic               cnt_we;
	logic               down_we;
	logic               up_we;
	addr_t              wr_addr;
	logic               over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		done       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = ST_RD2;
			ST_RD2: state_d = ST_CALC;
			ST_CALC: begin
				if (!result_valid_q || !result_stall) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = item_valid && !item_stall;

	always_comb begin
		mem_req.rd_en        = (state_q == ST_RD0) || (state_q == ST_RD1) ||
			(state_q == ST_RD2);
		mem_req.down_rd_addr = slot(item_q.node, item_q.char_index);
		mem_req.up_rd_addr   = slot(item_q.ancestor, item_q.char_index);
		mem_req.down_wr_en   = done && down_we;
		mem_req.up_wr_en     = done && up_we;
		mem_req.wr_addr      = wr_addr;
		mem_req.wr_data      = res;
		unique case (state_q)
			ST_RD0: begin
				if (item_q.action == ACT_DOWN || item_q.action == ACT_UP) begin
					mem_req.down_rd_addr = slot(item_q.left, item_q.char_index);
				end
				if (item_q.action == ACT_LOCAL) begin
					mem_req.up_rd_addr = slot(item_q.left, item_q.char_index);
				end
			end
			ST_RD1: begin
				mem_req.down_rd_addr = slot(item_q.right, item_q.char_index);
				mem_req.up_rd_addr   = slot(item_q.right, item_q.char_index);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_RD1) begin
			d0_q <= mem_rsp.down_rd_data;
			u0_q <= mem_rsp.up_rd_data;
		end
		if (state_q == ST_RD2) begin
			d1_q <= mem_rsp.down_rd_data;
			u1_q <= mem_rsp.up_rd_data;
		end
	end

	// The third read lands in the output register of the memory and holds
	// there through the update, as no read is issued in that state.
	assign d2 = mem_rsp.down_rd_data;

	always_comb begin
		res     = '0;
		tmp     = '0;
		cost    = '0;
		cnt_d   = cnt_rd_data;
		cnt_we  = 1'b0;
		down_we = 1'b0;
		up_we   = 1'b0;
		over    = 1'b0;
		wr_addr = slot(item_q.node, item_q.char_index);
		base    = item_q.first_of_pass ? '0 : pass_q;
		pass_d  = base;
		total_d = total_q;
		unique case (item_q.action)
			ACT_DOWN: begin
				res = d0_q & d1_q;
				if (res == '0) begin
					res    = d0_q | d1_q;
					cost   = item_q.weight;
					cnt_we = 1'b1;
					cnt_d  = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + 1'b1;
				end
				down_we = 1'b1;
				pass_d  = sat_add(base, cost);
				total_d = sat_add(total_q, cost);
			end
			ACT_ROOT: begin
				res     = d0_q;
				wr_addr = slot(item_q.ancestor, item_q.char_index);
				down_we = 1'b1;
				up_we   = 1'b1;
			end
			ACT_UP: begin
				res = u0_q & d2;
				if (res != u0_q) begin
					if ((d0_q & d1_q) != '0) begin
						res = d2 | (u0_q & (d0_q | d1_q));
					end else begin
						res = d2 | u0_q;
					end
				end
				up_we = 1'b1;
			end
			ACT_TIP: begin
				tmp   = d0_q & u0_q;
				res   = (tmp != '0) ? tmp : d0_q;
				up_we = 1'b1;
			end
			ACT_LOCAL: begin
				tmp = (u0_q | u1_q) & d0_q;
				if (tmp == '0) begin
					cost = item_q.weight;
				end
				pass_d = sat_add(base, cost);
				over   = item_q.limit_on && (pass_d > item_q.limit);
			end
			ACT_LOAD: begin
				res     = SET_W'(item_q.set_value);
				down_we = 1'b1;
			end
			default: begin
				pass_d = pass_q;
			end
		endcase
	end

	assign cnt_req.rd_en   = (state_q == ST_RD0);
	assign cnt_req.rd_addr = item_q.char_index[CHAR_W-1:0];
	assign cnt_req.wr_en   = done && cnt_we;
	assign cnt_req.wr_addr = item_q.char_index[CHAR_W-1:0];
	assign cnt_req.wr_data = cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q         <= '0;
			total_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (done) begin
				pass_q         <= pass_d;
				total_q        <= total_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			result_q.result_set   <= 32'(res);
			result_q.cost_added   <= cost;
			result_q.pass_cost    <= pass_d;
			result_q.total_score  <= total_d;
			result_q.change_count <= cnt_d;
			result_q.over_limit   <= over;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: design/fitch_parsimony_set_engine.sv
// ----------------------------------------------------------------------------
// Fitch parsimony set engine
// Each beat applies one Fitch operation to one character. An item is taken
// in an idle cycle and passes through the RD0, RD1, RD2 and CALC states,
// and its result is registered when CALC ends; no new item is taken before
// that, as the single read port of each set memory serves one operand per
// cycle and the up-pass needs three down sets. The write-back waits while
// an earlier result is still held in the output register; no new item is
// accepted meanwhile. No clearing pass runs after reset; change counters are cleared at once by reset.
// ----------------------------------------------------------------------------
module fitch_parsimony_set_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  fps_pkg::item_beat_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output fps_pkg::result_beat_t result
);
	import fps_pkg::*;

	set_mem_req_t     mem_req;
	set_mem_rsp_t     mem_rsp;
	cnt_req_t         cnt_req;
	logic [CNT_W-1:0] cnt_rd_data;

	fps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mem_req      (mem_req),
		.mem_rsp      (mem_rsp),
		.cnt_req      (cnt_req),
		.cnt_rd_data  (cnt_rd_data)
	);

	fps_set_mem u_set_mem (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	fps_count_mem u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_data (cnt_rd_data)
	);

endmodule

// File: design/fps_checker.sv
// ----------------------------------------------------------------------------
// Fitch parsimony set engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "fitch_parsimony_set_engine_assert.svh"

module fps_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input fps_pkg::result_beat_t result
);
	import fps_pkg::*;

	`FPS_ASSERT_NEXT(a_result_held, result_valid && result_stall,
		result_valid && $stable(result), "Stalled result beat changed or dropped.")

	`FPS_ASSERT_NEXT(a_one_at_a_time, item_valid && !item_stall,
		item_stall, "A second item was taken right after an accepted one.")

	`FPS_ASSERT_SAME(a_cost_in_pass, result_valid && (result.cost_added != '0),
		result.pass_cost != '0, "A charged beat shows a zero pass cost.")

	`FPS_ASSERT_SAME(a_over_limit, result_valid && result.over_limit,
		(result.result_set == '0) && (result.pass_cost != '0),
		"Over-limit beat carries a set or a zero pass cost.")

endmodule

bind fitch_parsimony_set_engine fps_checker u_fps_checker (.*);

// File: test/fitch_parsimony_set_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fitch parsimony set engine testbench
// A table of directed beats covers every operation, the unused action codes
// and the field extremes. Random Fitch passes follow (tip loads, down-pass,
// root copy, up-pass, tip update, local check) mixed with random items. Each
// result is checked against a fixed table value or an in-bench model of the
// sets, costs and change counts, under three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module fitch_parsimony_set_engine_test;
	import fps_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int ITEM_TARGET    = 1200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct {
		item_beat_t   beat;
		bit           fixed;
		result_beat_t want;
	} directed_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         item_valid;
	logic         item_stall;
	item_beat_t   item;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_beat_t result;

	set_t        down_model [DEPTH];
	set_t        up_model [DEPTH];
	bit          down_written [DEPTH];
	bit          up_written [DEPTH];
	logic [15:0] char_changes [CHARS];
	logic [31:0] score;
	logic [31:0] run_cost;
	logic [5:0]  recent_nodes [$];

	result_beat_t  expected_results [$];
	directed_row_t directed_rows [$];

	int items_sent;
	int results_seen;
	int charged_steps;
	int over_hits;
	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int stall_pct;

	fitch_parsimony_set_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] add_saturating(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {17'd0, b};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic void note_node(input logic [5:0] n);
		recent_nodes.push_back(n);
		if (recent_nodes.size() > 16)
			void'(recent_nodes.pop_front());
	endfunction

	function automatic void store_down(input logic [5:0] n, input logic [7:0] ch, input set_t v);
		down_model[{n, ch}] = v;
		down_written[{n, ch}] = 1'b1;
		note_node(n);
	endfunction

	function automatic void store_up(input logic [5:0] n, input logic [7:0] ch, input set_t v);
		up_model[{n, ch}] = v;
		up_written[{n, ch}] = 1'b1;
		note_node(n);
	endfunction

	// Applies one operation to the model state and returns the result it causes.
	function automatic result_beat_t apply_fitch_op(input item_beat_t b);
		result_beat_t r;
		set_t lhs, rhs, anc_up, own, joined;
		logic [7:0] ch;
		ch = b.char_index;
		r = '0;
		if (b.action <= ACT_LOAD && b.first_of_pass)
			run_cost = '0;
		case (b.action)
		ACT_DOWN: begin
			lhs = down_model[{b.left, ch}];
			rhs = down_model[{b.right, ch}];
			r.result_set = lhs & rhs;
			if (r.result_set == '0) begin
				r.result_set = lhs | rhs;
				r.cost_added = b.weight;
				if (char_changes[ch] != 16'hFFFF)
					char_changes[ch] = char_changes[ch] + 16'd1;
			end
			store_down(b.node, ch, r.result_set);
			run_cost = add_saturating(run_cost, r.cost_added);
			score = add_saturating(score, r.cost_added);
		end
		ACT_ROOT: begin
			r.result_set = down_model[{b.node, ch}];
			store_down(b.ancestor, ch, r.result_set);
			store_up(b.ancestor, ch, r.result_set);
		end
		ACT_UP: begin
			anc_up = up_model[{b.ancestor, ch}];
			own = down_model[{b.node, ch}];
			lhs = down_model[{b.left, ch}];
			rhs = down_model[{b.right, ch}];
			r.result_set = anc_up & own;
			if (r.result_set != anc_up)
				r.result_set = ((lhs & rhs) != '0) ? (own | (anc_up & (lhs | rhs)))
					: (own | anc_up);
			store_up(b.node, ch, r.result_set);
		end
		ACT_TIP: begin
			own = down_model[{b.node, ch}];
			joined = own & up_model[{b.ancestor, ch}];
			r.result_set = (joined != '0) ? joined : own;
			store_up(b.node, ch, r.result_set);
		end
		ACT_LOCAL: begin
			joined = up_model[{b.left, ch}] | up_model[{b.right, ch}];
			own = down_model[{b.node, ch}];
			if ((joined & own) == '0)
				r.cost_added = b.weight;
			run_cost = add_saturating(run_cost, r.cost_added);
			r.over_limit = b.limit_on && (run_cost > b.limit);
		end
		ACT_LOAD: begin
			r.result_set = b.set_value;
			store_down(b.node, ch, r.result_set);
		end
		default: ;
		endcase
		r.pass_cost = run_cost;
		r.total_score = score;
		r.change_count = char_changes[ch];
		return r;
	endfunction

	// True when every set the operation reads has been written before.
	function automatic bit reads_defined(input item_beat_t b);
		logic [7:0] ch;
		ch = b.char_index;
		case (b.action)
		ACT_DOWN:  return down_written[{b.left, ch}] && down_written[{b.right, ch}];
		ACT_ROOT:  return down_written[{b.node, ch}];
		ACT_UP:    return up_written[{b.ancestor, ch}] && down_written[{b.node, ch}]
			&& down_written[{b.left, ch}] && down_written[{b.right, ch}];
		ACT_TIP:   return down_written[{b.node, ch}] && up_written[{b.ancestor, ch}];
		ACT_LOCAL: return up_written[{b.left, ch}] && up_written[{b.right, ch}]
			&& down_written[{b.node, ch}];
		default:   return 1'b1;
		endcase
	endfunction

	function automatic item_beat_t beat_of(input logic [2:0] act, input logic [5:0] n,
			input logic [5:0] l, input logic [5:0] r, input logic [5:0] anc,
			input logic [7:0] ch, input logic [15:0] w, input logic [31:0] setv,
			input logic [31:0] lim, input logic lim_on, input logic first);
		item_beat_t b;
		b.action = act;
		b.node = n;
		b.left = l;
		b.right = r;
		b.ancestor = anc;
		b.char_index = ch;
		b.weight = w;
		b.set_value = setv;
		b.limit = lim;
		b.limit_on = lim_on;
		b.first_of_pass = first;
		return b;
	endfunction

	function automatic result_beat_t result_of(input logic [31:0] setv, input logic [15:0] cost,
			input logic [31:0] pass, input logic [31:0] total, input logic [15:0] cnt,
			input logic over);
		result_beat_t r;
		r.result_set = setv;
		r.cost_added = cost;
		r.pass_cost = pass;
		r.total_score = total;
		r.change_count = cnt;
		r.over_limit = over;
		return r;
	endfunction

	function automatic logic [31:0] random_set();
		case ($urandom_range(0, 7))
		0, 1: return $urandom;
		2: return '0;
		3: return '1;
		default: return (32'd1 << $urandom_range(0, 3))
			| (($urandom_range(0, 1) == 1) ? (32'd1 << $urandom_range(0, 31)) : 32'd0);
		endcase
	endfunction

	function automatic logic [15:0] random_weight();
		return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 'h300));
	endfunction

	function automatic logic [7:0] pick_char();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 7));
	endfunction

	function automatic logic [5:0] pick_node();
		if (recent_nodes.size() == 0 || $urandom_range(0, 1) == 0)
			return 6'($urandom);
		return recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
	endfunction

	// A limit close to the running cost, so both outcomes of the check occur.
	function automatic logic [31:0] near_limit();
		logic [31:0] delta;
		delta = $urandom_range(0, 'h200);
		if ($urandom_range(0, 1) == 1)
			return run_cost + delta;
		return (run_cost > delta) ? run_cost - delta : 32'd0;
	endfunction

	function automatic item_beat_t random_item();
		return beat_of(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom), 6'($urandom),
			6'($urandom), 8'($urandom), random_weight(), random_set(), $urandom,
			1'($urandom), $urandom_range(0, 7) == 0);
	endfunction

	function automatic item_beat_t fitch_beat(input logic [2:0] act, input logic [5:0] n,
			input logic [5:0] l, input logic [5:0] r, input logic [5:0] anc,
			input logic [7:0] ch, input logic [15:0] w);
		item_beat_t b;
		b = random_item();
		b.action = act;
		b.node = n;
		b.left = l;
		b.right = r;
		b.ancestor = anc;
		b.char_index = ch;
		b.weight = w;
		b.first_of_pass = 1'b0;
		if (act == ACT_LOCAL)
			b.limit = near_limit();
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic check_result(input result_beat_t got);
		result_beat_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending", got.result_set, '0);
			return;
		end
		want = expected_results.pop_front();
		compare_field("result_set", got.result_set, want.result_set);
		compare_field("cost_added", 32'(got.cost_added), 32'(want.cost_added));
		compare_field("pass_cost", got.pass_cost, want.pass_cost);
		compare_field("total_score", got.total_score, want.total_score);
		compare_field("change_count", 32'(got.change_count), 32'(want.change_count));
		compare_field("over_limit", 32'(got.over_limit), 32'(want.over_limit));
		if (want.cost_added != '0)
			charged_steps++;
		if (want.over_limit)
			over_hits++;
	endtask

	task automatic send_beat(input item_beat_t b, input result_beat_t want);
		if (items_sent < ITEM_TARGET / 3) begin
			send_idle_pct = 11;
			stall_pct = 47;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			send_idle_pct = 47;
			stall_pct = 11;
		end else begin
			send_idle_pct = 0;
			stall_pct = 0;
		end
		expected_results.push_back(want);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= b;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_predicted(input item_beat_t b);
		send_beat(b, apply_fitch_op(b));
	endtask

	// One well-formed pass over a four-tip tree for one character.
	task automatic run_fitch_pass();
		logic [5:0] tip [4];
		logic [5:0] mid_a, mid_b, apex, above;
		logic [7:0] ch;
		logic [15:0] w;
		item_beat_t b;
		ch = pick_char();
		w = random_weight();
		foreach (tip[i])
			tip[i] = 6'($urandom);
		mid_a = 6'($urandom);
		mid_b = 6'($urandom);
		apex = 6'($urandom);
		above = 6'($urandom);
		for (int i = 0; i < 4; i++) begin
			b = fitch_beat(ACT_LOAD, tip[i], 6'($urandom), 6'($urandom), 6'($urandom), ch, w);
			b.first_of_pass = (i == 0) && ($urandom_range(0, 3) != 0);
			send_predicted(b);
		end
		send_predicted(fitch_beat(ACT_DOWN, mid_a, tip[0], tip[1], 6'($urandom), ch, w));
		send_predicted(fitch_beat(ACT_DOWN, mid_b, tip[2], tip[3], 6'($urandom), ch, w));
		send_predicted(fitch_beat(ACT_DOWN, apex, mid_a, mid_b, 6'($urandom), ch, w));
		send_predicted(fitch_beat(ACT_ROOT, apex, 6'($urandom), 6'($urandom), above, ch, w));
		send_predicted(fitch_beat(ACT_UP, apex, mid_a, mid_b, above, ch, w));
		send_predicted(fitch_beat(ACT_UP, mid_a, tip[0], tip[1], apex, ch, w));
		send_predicted(fitch_beat(ACT_UP, mid_b, tip[2], tip[3], apex, ch, w));
		for (int i = 0; i < 4; i++)
			send_predicted(fitch_beat(ACT_TIP, tip[i], 6'($urandom), 6'($urandom),
				(i < 2) ? mid_a : mid_b, ch, w));
		send_predicted(fitch_beat(ACT_LOCAL, tip[$urandom_range(0, 3)],
			($urandom_range(0, 1) == 1) ? mid_a : apex, mid_b, 6'($urandom), ch, w));
	endtask

	task automatic send_noise_beat();
		item_beat_t b;
		int tries;
		tries = 0;
		do begin
			b = random_item();
			b.char_index = pick_char();
			b.node = pick_node();
			b.left = pick_node();
			b.right = pick_node();
			b.ancestor = pick_node();
			tries++;
		end while (!reads_defined(b) && tries < 40);
		if (!reads_defined(b))
			b.action = ACT_LOAD;
		if (b.action == ACT_LOCAL)
			b.limit = near_limit();
		send_predicted(b);
	endtask

	always @(posedge clk) begin
		result_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		result_beat_t predicted;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		score = '0;
		run_cost = '0;
		foreach (char_changes[i])
			char_changes[i] = '0;
		send_idle_pct = 11;
		stall_pct = 47;

		directed_rows.push_back('{beat_of(ACT_LOAD, 63, 0, 0, 0, 255, 0, '1, 0, 0, 0), 1'b1,
			result_of('1, 0, 0, 0, 0, 0)});
		directed_rows.push_back('{beat_of(ACT_LOAD, 0, 0, 0, 0, 255, 0, 0, 0, 0, 0), 1'b1,
			result_of(0, 0, 0, 0, 0, 0)});
		directed_rows.push_back('{beat_of(ACT_DOWN, 1, 63, 0, 0, 255, 'hFFFF, 0, 0, 0, 1), 1'b1,
			result_of('1, 'hFFFF, 'hFFFF, 'hFFFF, 1, 0)});
		directed_rows.push_back('{beat_of(ACT_DOWN, 2, 63, 63, 0, 255, 'hFFFF, 0, 0, 0, 0),
			1'b1, result_of('1, 0, 'hFFFF, 'hFFFF, 1, 0)});
		directed_rows.push_back('{beat_of(ACT_DOWN, 3, 0, 0, 0, 255, 0, 0, 0, 0, 0), 1'b1,
			result_of(0, 0, 'hFFFF, 'hFFFF, 2, 0)});
		directed_rows.push_back('{beat_of(ACT_SPARE7, 0, 0, 0, 0, 255, 0, 0, 0, 0, 1), 1'b1,
			result_of(0, 0, 'hFFFF, 'hFFFF, 2, 0)});
		directed_rows.push_back('{beat_of(ACT_SPARE6, 63, 63, 63, 63, 0, 'hFFFF, '1, '1, 1, 1),
			1'b1, result_of(0, 0, 'hFFFF, 'hFFFF, 0, 0)});
		directed_rows.push_back('{beat_of(ACT_ROOT, 1, 0, 0, 62, 255, 0, 0, 0, 0, 0), 1'b1,
			result_of('1, 0, 'hFFFF, 'hFFFF, 2, 0)});
		directed_rows.push_back('{beat_of(ACT_UP, 1, 63, 0, 62, 255, 0, 0, 0, 0, 0), 1'b1,
			result_of('1, 0, 'hFFFF, 'hFFFF, 2, 0)});
		directed_rows.push_back('{beat_of(ACT_TIP, 0, 0, 0, 1, 255, 0, 0, 0, 0, 0), 1'b1,
			result_of(0, 0, 'hFFFF, 'hFFFF, 2, 0)});
		directed_rows.push_back('{beat_of(ACT_TIP, 63, 0, 0, 1, 255, 0, 0, 0, 0, 0), 1'b1,
			result_of('1, 0, 'hFFFF, 'hFFFF, 2, 0)});
		directed_rows.push_back('{beat_of(ACT_LOCAL, 0, 1, 63, 0, 255, 'hFFFF, 0, 0, 1, 1),
			1'b1, result_of(0, 'hFFFF, 'hFFFF, 'hFFFF, 2, 1)});
		directed_rows.push_back('{beat_of(ACT_LOCAL, 63, 1, 1, 0, 255, 'h0100, 0, '1, 1, 0),
			1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_LOCAL, 0, 1, 0, 0, 255, 'hFFFF, 0, 0, 0, 0),
			1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_LOAD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_LOAD, 63, 0, 0, 0, 0, 0, 2, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_DOWN, 5, 0, 63, 0, 0, 'h0100, 0, 0, 0, 1),
			1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_DOWN, 6, 0, 0, 0, 0, 'h0200, 0, 0, 0, 0),
			1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_DOWN, 7, 5, 6, 0, 0, 'h0080, 0, 0, 0, 0),
			1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_ROOT, 7, 0, 0, 9, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_UP, 7, 5, 6, 9, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_UP, 5, 0, 63, 7, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_TIP, 0, 0, 0, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_TIP, 63, 0, 0, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{beat_of(ACT_LOCAL, 6, 5, 63, 0, 0, 'h0180, 0, 'h0100, 1, 0),
			1'b0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			predicted = apply_fitch_op(directed_rows[i].beat);
			send_beat(directed_rows[i].beat,
				directed_rows[i].fixed ? directed_rows[i].want : predicted);
		end

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) < 7)
				run_fitch_pass();
			else
				send_noise_beat();
		end
		item_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items and checked %0d results across Fitch passes and random beats.",
			items_sent, results_seen);
		$display("Weight was charged on %0d results; the local limit tripped %0d times.",
			charged_steps, over_hits);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
